/* design/nvram_controller_registers_defines.svh */
// ---------------------------------------------------------------------------
// NVRAM controller assertion macros
// Shared property shorthands; they expect clk and rst in the calling scope.
// ---------------------------------------------------------------------------
`ifndef NVRAM_CONTROLLER_REGISTERS_DEFINES_SVH
`define NVRAM_CONTROLLER_REGISTERS_DEFINES_SVH

// same-cycle implication, muted during reset
`define NVR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted during reset
`define NVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after a reset edge
`define NVR_ASSERT_POST_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

/* design/nvr_pkg.sv */
// ---------------------------------------------------------------------------
// nvr_pkg
// Types and constants shared by the NVRAM controller modules.
// ---------------------------------------------------------------------------
package nvr_pkg;

  // item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // address window limits
  localparam logic [15:0] SRAM_LIMIT    = 16'h8000;
  localparam logic [15:0] SCRATCH_LIMIT = 16'hC000;
  localparam logic [15:0] STATUS_LIMIT  = 16'hE000;

  // command opcodes with a copy
  localparam logic [7:0] OP_STORE = 8'd2;
  localparam logic [7:0] OP_LOAD  = 8'd3;

  // command countdown after reset
  localparam logic [15:0] DELAY_RESET = 16'd6000;

  // SRAM window word offset is address[14:2]
  localparam int WORD_W = 13;

  // controller -> datapath
  typedef struct packed {
    logic exec;        // transfer accepted this cycle
    logic mem_op;      // SRAM access using the latched word index
    logic rsp_load;    // capture a result into the output register
    logic rsp_mem;     // result comes from SRAM read data
    logic clear_step;  // zero one word of both stores
    logic copy_step;   // read one word of the copy source
  } nvr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sram_acc;    // item needs an SRAM access
    logic sram_rd;     // that access is a read
    logic copy_go;     // item finishes a store or load command
    logic mem_write;   // latched SRAM access is a write
    logic sweep_last;  // sweep counter at the last word
  } nvr_stat_t;

endpackage

/* design/nvr_ifs.sv */
// ---------------------------------------------------------------------------
// nvr_req_if / nvr_rsp_if
// Valid/ready channels for bus items and their results.
// ---------------------------------------------------------------------------
interface nvr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [31:0] write_data;
  logic        secure;

  modport source (output valid, kind, address, write_data, secure, input ready);
  modport sink   (input valid, kind, address, write_data, secure, output ready);
endinterface

interface nvr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        ignored;

  modport source (output valid, read_data, ignored, input ready);
  modport sink   (input valid, read_data, ignored, output ready);
endinterface

/* design/nvr_ctrl.sv */
// ---------------------------------------------------------------------------
// nvr_ctrl
// Sequencer: clearing pass, item intake, SRAM access, copy walk, result valid.
// ---------------------------------------------------------------------------
module nvr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  nvr_pkg::nvr_stat_t stat,
  output nvr_pkg::nvr_cmd_t  cmd
);
  import nvr_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ADDR  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_COPY  = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  // output register can take a result this cycle
  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign accept = req_valid && req_ready;

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.exec     = 1'b1;
          cmd.rsp_load = !stat.sram_rd;
          if (stat.sram_acc) state_next = ST_ADDR;
          else if (stat.copy_go) state_next = ST_COPY;
        end
      end
      ST_ADDR: begin
        cmd.mem_op = 1'b1;
        state_next = stat.mem_write ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        cmd.rsp_load = 1'b1;
        cmd.rsp_mem  = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last copy write lands this cycle
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

/* design/nvr_dp.sv */
// ---------------------------------------------------------------------------
// nvr_dp
// Datapath: SRAM and flash stores, scratch registers, status, countdown.
// ---------------------------------------------------------------------------
module nvr_dp #(
  parameter int STORE_WORDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic [1:0]         kind,
  input  logic [15:0]        address,
  input  logic [31:0]        write_data,
  input  logic               secure,
  output logic [31:0]        read_data,
  output logic               ignored,
  input  nvr_pkg::nvr_cmd_t  cmd,
  output nvr_pkg::nvr_stat_t stat
);
  import nvr_pkg::*;

  localparam int IDX_W = $clog2(STORE_WORDS);
  // floor(2^WORD_W / STORE_WORDS), quotient estimate off by at most one
  localparam logic [9:0]  RECIP   = 10'((1 << WORD_W) / STORE_WORDS);
  localparam logic [13:0] STORE_L = 14'(STORE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_WORDS - 1);

  typedef enum logic [3:0] {
    WIN_SRAM    = 4'b0001,
    WIN_SCRATCH = 4'b0010,
    WIN_STATUS  = 4'b0100,
    WIN_CMD     = 4'b1000
  } win_t;

  // stores
  logic [31:0] sram  [STORE_WORDS];
  logic [31:0] flash [STORE_WORDS];
  logic [31:0] scratch [8];

  // control state
  logic [15:0] command_delay;
  logic        busy, load_done, store_done, finished;
  logic [7:0]  pending_opcode;
  logic [15:0] ticks_left;
  logic [IDX_W-1:0] sweep_idx;
  logic             copy_wr_en;
  logic [IDX_W-1:0] copy_widx;

  // latched SRAM access
  logic [WORD_W-1:0] acc_word;
  logic [9:0]        acc_q;
  logic [31:0]       acc_data;
  logic              acc_wr;

  // memory ports
  logic [31:0]       sram_rdata, flash_rdata;
  logic              sram_we, flash_we;
  logic [IDX_W-1:0]  sram_waddr, sram_raddr, flash_waddr;
  logic [31:0]       sram_wdata, flash_wdata;

  // decode
  win_t        win;
  logic        is_rd, is_wr, is_tick, acc, tick_done, copy_load;
  logic [31:0] status_word, rd_now;
  logic [22:0] q_prod;
  logic [23:0] back_prod;
  logic [WORD_W-1:0] rem0, rem;
  logic [IDX_W-1:0]  mem_idx;

  always_comb begin
    if (address < SRAM_LIMIT) win = WIN_SRAM;
    else if (address < SCRATCH_LIMIT) win = WIN_SCRATCH;
    else if (address < STATUS_LIMIT) win = WIN_STATUS;
    else win = WIN_CMD;
  end

  assign is_rd     = (kind == KIND_READ);
  assign is_wr     = (kind == KIND_WRITE);
  assign is_tick   = (kind == KIND_TICK);
  assign acc       = (is_rd || is_wr) && secure;
  assign tick_done = is_tick && busy && (ticks_left <= 16'd1);
  assign copy_load = (pending_opcode == OP_LOAD);

  assign status_word = {1'b0, finished, store_done, 5'b0, load_done, 22'b0, busy};

  assign stat.sram_acc   = acc && (win == WIN_SRAM);
  assign stat.sram_rd    = acc && (win == WIN_SRAM) && is_rd;
  assign stat.copy_go    = tick_done && (pending_opcode == OP_STORE || copy_load);
  assign stat.mem_write  = acc_wr;
  assign stat.sweep_last = (sweep_idx == LAST_IDX);

  // immediate read data for non-SRAM windows
  always_comb begin
    rd_now = '0;
    if (acc && is_rd) begin
      unique case (win)
        WIN_SCRATCH: rd_now = scratch[address[4:2]];
        WIN_STATUS:  rd_now = status_word;
        WIN_SRAM,
        WIN_CMD:     rd_now = '0;
        default:     rd_now = '0;
      endcase
    end
  end

  // word index modulo STORE_WORDS: reciprocal estimate, then one correction
  assign q_prod    = 23'(address[14:2]) * 23'(RECIP);
  assign back_prod = 24'(acc_q) * 24'(STORE_L);
  assign rem0      = acc_word - back_prod[WORD_W-1:0];
  assign rem       = ({1'b0, rem0} >= STORE_L) ? (rem0 - STORE_L[WORD_W-1:0]) : rem0;
  assign mem_idx   = rem[IDX_W-1:0];

  // latch SRAM access on transfer
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_word <= address[14:2];
      acc_q    <= q_prod[22:13];
      acc_data <= write_data;
      acc_wr   <= is_wr;
    end
  end

  // flags, countdown, scratch, config
  always_ff @(posedge clk) begin
    if (rst) begin
      command_delay  <= DELAY_RESET;
      busy           <= 1'b0;
      load_done      <= 1'b0;
      store_done     <= 1'b0;
      finished       <= 1'b0;
      pending_opcode <= '0;
      ticks_left     <= '0;
      for (int i = 0; i < 8; i++) scratch[i] <= '0;
    end else begin
      if (cfg_we) command_delay <= cfg_wdata;
      if (cmd.exec) begin
        // countdown tick
        if (is_tick && busy) begin
          if (ticks_left <= 16'd1) begin
            ticks_left <= '0;
            busy       <= 1'b0;
            finished   <= 1'b1;
            if (pending_opcode == OP_STORE) store_done <= 1'b1;
            else if (copy_load) load_done <= 1'b1;
          end else begin
            ticks_left <= ticks_left - 16'd1;
          end
        end
        // register writes
        if (acc && is_wr) begin
          unique case (win)
            WIN_SCRATCH: scratch[address[4:2]] <= write_data;
            WIN_STATUS:  finished <= 1'b1;
            WIN_CMD: begin
              if (!busy) begin
                finished       <= 1'b0;
                busy           <= 1'b1;
                pending_opcode <= write_data[31:24];
                ticks_left     <= command_delay;
              end
            end
            WIN_SRAM: ;
            default: ;
          endcase
        end
      end
    end
  end

  // sweep counter shared by clearing pass and copy walk
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx  <= '0;
      copy_wr_en <= 1'b0;
    end else begin
      copy_wr_en <= cmd.copy_step;
      if (cmd.clear_step || cmd.copy_step) begin
        sweep_idx <= stat.sweep_last ? '0 : sweep_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_widx <= sweep_idx;
  end

  // SRAM port selection
  always_comb begin
    sram_we    = cmd.clear_step || (cmd.mem_op && acc_wr) || (copy_wr_en && copy_load);
    sram_waddr = copy_widx;
    sram_wdata = flash_rdata;
    if (cmd.clear_step) begin
      sram_waddr = sweep_idx;
      sram_wdata = '0;
    end else if (cmd.mem_op) begin
      sram_waddr = mem_idx;
      sram_wdata = acc_data;
    end
  end
  assign sram_raddr = cmd.mem_op ? mem_idx : sweep_idx;

  // flash port selection
  assign flash_we    = cmd.clear_step || (copy_wr_en && !copy_load);
  assign flash_waddr = cmd.clear_step ? sweep_idx : copy_widx;
  assign flash_wdata = cmd.clear_step ? '0 : sram_rdata;

  // SRAM store
  always_ff @(posedge clk) begin
    if (sram_we) sram[sram_waddr] <= sram_wdata;
    sram_rdata <= sram[sram_raddr];
  end

  // flash store
  always_ff @(posedge clk) begin
    if (flash_we) flash[flash_waddr] <= flash_wdata;
    flash_rdata <= flash[sweep_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      if (cmd.rsp_mem) begin
        read_data <= sram_rdata;
        ignored   <= 1'b0;
      end else begin
        read_data <= rd_now;
        ignored   <= ((is_rd || is_wr) && !secure)
                     || (acc && is_wr && (win == WIN_CMD) && busy);
      end
    end
  end

endmodule

/* design/nvram_controller_registers.sv */
// Results are loaded into the output register at transfer, SRAM reads in the READ state after ADDR; the
// next transfer waits for ADDR after an SRAM write and for ADDR and READ after a read. A tick that ends a
// store or load command walks the stores one word per cycle through the memory ports: intake resumes after
// the COPY and DRAIN states. Throughput: one item per cycle for ticks that start no copy walk, register and
// status accesses, while the receiver takes each result. Reset (rst, synchronous): a clearing pass zeroes
// both stores; no item is taken during it, configuration writes are.
// ---------------------------------------------------------------------------
// nvram_controller_registers
// Secure-mode NVRAM controller with SRAM, scratch, status and command windows.
// ---------------------------------------------------------------------------
module nvram_controller_registers #(
  parameter int STORE_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  nvr_req_if.sink     req,
  nvr_rsp_if.source   rsp
);
  import nvr_pkg::*;

  nvr_cmd_t  cmd;
  nvr_stat_t stat;

  // sequencer
  nvr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stores and registers
  nvr_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .kind       (req.kind),
    .address    (req.address),
    .write_data (req.write_data),
    .secure     (req.secure),
    .read_data  (rsp.read_data),
    .ignored    (rsp.ignored),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

/* design/nvr_checker.sv */
// ---------------------------------------------------------------------------
// nvr_checker
// Port-level checks for the NVRAM controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "nvram_controller_registers_defines.svh"

module nvr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_kind,
  input logic        req_secure,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_read_data,
  input logic        rsp_ignored
);
  import nvr_pkg::*;

  logic req_xfer;
  logic bus_acc;

  assign req_xfer = req_valid && req_ready;
  assign bus_acc  = (req_kind == KIND_READ) || (req_kind == KIND_WRITE);

  // clearing pass blocks intake right after reset
  `NVR_ASSERT_POST_RESET(a_clear_blocks, !req_ready, "item taken during clearing pass")

  // refused access answers next cycle, flagged, with zero data
  `NVR_ASSERT_NEXT(a_refused, req_xfer && bus_acc && !req_secure, rsp_valid && rsp_ignored && (rsp_read_data == 32'd0), "refused access result wrong")

  // tick answers next cycle, never flagged
  `NVR_ASSERT_NEXT(a_tick, req_xfer && (req_kind == KIND_TICK), rsp_valid && !rsp_ignored && (rsp_read_data == 32'd0), "tick result wrong")

  // a stalled result blocks intake
  `NVR_ASSERT_SAME(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready, "intake while result stalled")

  // stalled result holds
  `NVR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_ignored), "stalled result changed")

endmodule

bind nvram_controller_registers nvr_checker u_nvr_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_kind      (req.kind),
  .req_secure    (req.secure),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data),
  .rsp_ignored   (rsp.ignored)
);

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: NVRAM controller register block testbench
// Drives bus reads, writes and ticks through the request channel and checks
// every reply against an in-bench model of the SRAM, flash, scratch, status
// and command windows. Covers directed window accesses, command timing,
// several countdown settings, backpressure and random traffic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import nvr_pkg::*;

  localparam int STORE_WORDS = 64;
  localparam int STALL_LIMIT = 2000;          // cycles with no transfer at all
  localparam int SETTLE_CYCLES = STORE_WORDS + 4;
  localparam logic [1:0] KIND_NONE = 2'd3;    // unused kind, does nothing
  localparam logic [15:0] MAX_DELAY = 16'hFFFF;

  // status word bit positions
  localparam int ST_BUSY = 0;
  localparam int ST_LOAD = 23;
  localparam int ST_STORE = 29;
  localparam int ST_DONE = 30;

  typedef struct packed {
    logic [31:0] read_data;
    logic        ignored;
  } bus_reply_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  nvr_req_if req_ch ();
  nvr_rsp_if rsp_ch ();

  nvram_controller_registers #(.STORE_WORDS(STORE_WORDS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // model state
  logic [31:0] sram_words [STORE_WORDS];
  logic [31:0] flash_words [STORE_WORDS];
  logic [31:0] scratch_words [8];
  logic        busy_bit;
  logic        load_done_bit;
  logic        store_done_bit;
  logic        finished_bit;
  logic [7:0]  latched_opcode;
  logic [15:0] countdown;
  logic [15:0] command_delay_reg;

  bus_reply_t  bus_reply_q [$];
  int          mismatches = 0;
  bit          snd_idle_on = 1'b1;
  int unsigned rsp_hold_request = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // word index of the SRAM window
  function automatic int sram_slot(logic [15:0] addr);
    return (addr >> 2) % STORE_WORDS;
  endfunction

  // apply one accepted item to the model and return its reply
  function automatic bus_reply_t compute_bus_reply(logic [1:0] kind, logic [15:0] addr,
                                                   logic [31:0] data, logic secure);
    bus_reply_t rep;
    rep.read_data = '0;
    rep.ignored = 1'b0;
    if (kind == KIND_TICK) begin
      if (busy_bit) begin
        if (countdown <= 16'd1) begin
          countdown = '0;
          if (latched_opcode == OP_STORE) begin
            foreach (flash_words[i]) flash_words[i] = sram_words[i];
            store_done_bit = 1'b1;
          end else if (latched_opcode == OP_LOAD) begin
            foreach (sram_words[i]) sram_words[i] = flash_words[i];
            load_done_bit = 1'b1;
          end
          finished_bit = 1'b1;
          busy_bit = 1'b0;
        end else begin
          countdown = countdown - 16'd1;
        end
      end
    end else if (kind == KIND_READ || kind == KIND_WRITE) begin
      if (!secure) begin
        rep.ignored = 1'b1;
      end else if (kind == KIND_READ) begin
        if (addr < SRAM_LIMIT) begin
          rep.read_data = sram_words[sram_slot(addr)];
        end else if (addr < SCRATCH_LIMIT) begin
          rep.read_data = scratch_words[addr[4:2]];
        end else if (addr < STATUS_LIMIT) begin
          rep.read_data[ST_BUSY] = busy_bit;
          rep.read_data[ST_LOAD] = load_done_bit;
          rep.read_data[ST_STORE] = store_done_bit;
          rep.read_data[ST_DONE] = finished_bit;
        end
      end else begin
        if (addr < SRAM_LIMIT) begin
          sram_words[sram_slot(addr)] = data;
        end else if (addr < SCRATCH_LIMIT) begin
          scratch_words[addr[4:2]] = data;
        end else if (addr < STATUS_LIMIT) begin
          finished_bit = 1'b1;
        end else if (busy_bit) begin
          rep.ignored = 1'b1;
        end else begin
          finished_bit = 1'b0;
          busy_bit = 1'b1;
          latched_opcode = data[31:24];
          countdown = command_delay_reg;
        end
      end
    end
    return rep;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item, wait for its transfer, then log its reply
  task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [31:0] data, input logic secure);
    int unsigned gap;
    gap = (snd_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.address <= addr;
    req_ch.write_data <= data;
    req_ch.secure <= secure;
    do @(posedge clk); while (!req_ch.ready);
    bus_reply_q.push_back(compute_bus_reply(kind, addr, data, secure));
  endtask

  // stop offering and wait for every outstanding reply
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (bus_reply_q.size() != 0) @(posedge clk);
  endtask

  // countdown register write, only with the block idle
  task automatic set_command_delay(input logic [15:0] value);
    drain();
    // a copy walk can still be running after its tick has replied
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    command_delay_reg = value;
  endtask

  // one random item, weighted toward windows that reach deep state
  task automatic send_random_op();
    int unsigned r;
    logic        sec;
    logic [31:0] data;
    logic [7:0]  opcode;
    r = $urandom_range(0, 99);
    sec = ($urandom_range(0, 11) != 0);
    data = $urandom;
    case ($urandom_range(0, 3))
      0: opcode = OP_STORE;
      1: opcode = OP_LOAD;
      default: opcode = 8'($urandom);
    endcase
    if (r < 28) begin
      send_item(KIND_TICK, 16'($urandom), data, 1'($urandom));
    end else if (r < 43) begin
      send_item(KIND_WRITE, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'h7FFF)) :
                16'($urandom_range(0, 16'h00FF)), data, sec);
    end else if (r < 58) begin
      send_item(KIND_READ, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'h7FFF)) :
                16'($urandom_range(0, 16'h00FF)), data, sec);
    end else if (r < 66) begin
      send_item(KIND_WRITE, 16'($urandom_range(16'h8000, 16'hBFFF)), data, sec);
    end else if (r < 72) begin
      send_item(KIND_READ, 16'($urandom_range(16'h8000, 16'hBFFF)), data, sec);
    end else if (r < 80) begin
      send_item(KIND_READ, 16'($urandom_range(16'hC000, 16'hDFFF)), data, sec);
    end else if (r < 84) begin
      send_item(KIND_WRITE, 16'($urandom_range(16'hC000, 16'hDFFF)), data, sec);
    end else if (r < 94) begin
      send_item(KIND_WRITE, 16'($urandom_range(16'hE000, 16'hFFFF)), {opcode, data[23:0]},
                sec);
    end else if (r < 97) begin
      send_item(KIND_READ, 16'($urandom_range(16'hE000, 16'hFFFF)), data, sec);
    end else begin
      send_item(KIND_NONE, 16'($urandom), data, 1'($urandom));
    end
  endtask

  // window decode, secure gating and the odd kinds
  task automatic test_windows();
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
    send_item(KIND_WRITE, 16'h0000, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_READ, 16'h0003, '0, 1'b1);             // byte offset ignored
    send_item(KIND_WRITE, 16'h7FFF, 32'h1234_5678, 1'b1);
    send_item(KIND_READ, 16'h00FC, '0, 1'b1);
    send_item(KIND_READ, 16'h0100, '0, 1'b1);             // word index wraps
    send_item(KIND_WRITE, 16'h8000, 32'hA5A5_A5A5, 1'b1);
    send_item(KIND_WRITE, 16'hBFFF, 32'h5A5A_5A5A, 1'b1);
    send_item(KIND_READ, 16'hBFE0, '0, 1'b1);             // upper scratch bits ignored
    send_item(KIND_READ, 16'h9FFC, '0, 1'b1);
    send_item(KIND_WRITE, 16'h0000, 32'h0, 1'b0);         // refused, dropped
    send_item(KIND_READ, 16'h0000, '0, 1'b0);
    send_item(KIND_READ, 16'h0000, '0, 1'b1);
    send_item(KIND_READ, 16'hE000, '0, 1'b1);             // command read is zero
    send_item(KIND_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_WRITE, 16'hC000, 32'hFFFF_FFFF, 1'b1); // status write sets finished
    send_item(KIND_READ, 16'hDFFF, '0, 1'b1);
    send_item(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);  // tick while idle
    send_item(KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_NONE, 16'h0000, 32'h0, 1'b1);
  endtask

  // command lifecycle with zero, short and odd opcodes
  task automatic test_commands();
    set_command_delay(16'd0);                             // acts as one tick
    send_item(KIND_WRITE, 16'hE000, {OP_STORE, 24'hFF_FFFF}, 1'b1);
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
    send_item(KIND_WRITE, 16'hE004, {OP_LOAD, 24'h0}, 1'b1);   // busy, ignored
    send_item(KIND_WRITE, 16'hC004, 32'h0, 1'b1);         // status write while busy
    send_item(KIND_TICK, 16'h0000, 32'h0, 1'b0);          // completes the store
    send_item(KIND_WRITE, 16'h0000, 32'h0, 1'b1);
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
    set_command_delay(16'd2);
    send_item(KIND_WRITE, 16'hFFFF, {OP_LOAD, 24'h0}, 1'b1);
    send_item(KIND_TICK, 16'h1234, 32'h0, 1'b1);
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
    send_item(KIND_TICK, 16'h1234, 32'h0, 1'b1);          // completes the load
    send_item(KIND_READ, 16'h0000, '0, 1'b1);
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
    send_item(KIND_WRITE, 16'hF000, 32'hFF00_0000, 1'b1); // opcode with no copy
    send_item(KIND_TICK, 16'h0, 32'h0, 1'b0);
    send_item(KIND_TICK, 16'h0, 32'h0, 1'b0);
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
    send_item(KIND_WRITE, 16'hE000, {OP_STORE, 24'h0}, 1'b0);  // refused command
    send_item(KIND_READ, 16'hC000, '0, 1'b1);
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    snd_idle_on = 1'b0;
    rsp_hold_request = 400;
    repeat (40) send_random_op();
    drain();
    snd_idle_on = 1'b1;
  endtask

  // random traffic under several countdown settings
  task automatic test_random();
    logic [15:0] delays [4];
    delays = '{16'd1, 16'd7, 16'd40, 16'd0};
    delays[3] = 16'($urandom_range(2, 30));
    foreach (delays[p]) begin
      set_command_delay(delays[p]);
      repeat (312) begin
        if ($urandom_range(0, 59) == 0) snd_idle_on = !snd_idle_on;
        send_random_op();
      end
    end
    snd_idle_on = 1'b1;
  endtask

  // largest countdown: still busy after a stretch of ticks
  task automatic test_max_delay();
    set_command_delay(MAX_DELAY);
    snd_idle_on = 1'b0;
    send_item(KIND_WRITE, 16'hE000, {OP_STORE, 24'h0}, 1'b1);
    send_item(KIND_WRITE, 16'hE000, {OP_LOAD, 24'h0}, 1'b1);   // busy, ignored
    repeat (20) send_item(KIND_TICK, 16'($urandom), $urandom, 1'($urandom));
    send_item(KIND_READ, 16'hC000, '0, 1'b1);             // still busy
    snd_idle_on = 1'b1;
    drain();
  endtask

  // reply sink: random stalls plus requested long hold-offs
  initial begin : reply_sink
    int unsigned stall;
    bit          idle_on;
    stall = 0;
    idle_on = 1'b1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_request != 0) begin
        stall = rsp_hold_request;
        rsp_hold_request = 0;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
      if ($urandom_range(0, 299) == 0) idle_on = !idle_on;
    end
  end

  // compare each reply transfer with the oldest logged reply
  initial begin : reply_check
    bus_reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (bus_reply_q.size() == 0) begin
          $error("reply with none pending: read_data %h ignored %b",
                 rsp_ch.read_data, rsp_ch.ignored);
          mismatches++;
        end else begin
          want = bus_reply_q.pop_front();
          if (rsp_ch.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, rsp_ch.read_data);
            mismatches++;
          end
          if (rsp_ch.ignored !== want.ignored) begin
            $error("ignored: expected %b, actual %b", want.ignored, rsp_ch.ignored);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog: too long with no transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // sequence
  initial begin
    foreach (sram_words[i]) begin
      sram_words[i] = '0;
      flash_words[i] = '0;
    end
    foreach (scratch_words[i]) scratch_words[i] = '0;
    busy_bit = 1'b0;
    load_done_bit = 1'b0;
    store_done_bit = 1'b0;
    finished_bit = 1'b0;
    latched_opcode = '0;
    countdown = '0;
    command_delay_reg = DELAY_RESET;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_READ;
    req_ch.address <= '0;
    req_ch.write_data <= '0;
    req_ch.secure <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_windows();
    test_commands();
    test_backpressure();
    test_random();
    test_max_delay();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
